// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset
`define CHK_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle
`define CHK_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle
`define CHK_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHK_ALWAYS(name, clk, rst_n, cond, msg)
`define CHK_SAME(name, clk, rst_n, ante, cons, msg)
`define CHK_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/dofbd_pkg.sv =====
// ----------------------------------------------------------------------------
// dofbd_pkg
// Shared types and constants of the drop-oldest FIFO with burst drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dofbd_pkg;

    localparam int ITEM_W = 32;
    localparam int FILL_W = 5;
    localparam logic [FILL_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_ENQ   = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENQ,
        ST_DRAIN
    } state_t;

    // Word store control from the sequencer
    typedef struct packed {
        logic load;
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    // Result transaction control, aligned with the store read data
    typedef struct packed {
        logic              strobe;
        logic              valid;
        logic              last;
        logic [FILL_W-1:0] fill;
    } res_t;

endpackage
`default_nettype wire

// ===== hdl/drop_oldest_fifo_burst_drain.sv =====
// ----------------------------------------------------------------------------
// drop_oldest_fifo_burst_drain
// Bounded FIFO that drops its oldest word when full and drains in bursts.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken when start is high and busy is low.
//   op = 0 enqueues item_data; op = 1 drains up to drain_count words.
//   Results leave one per cycle on out_data/out_valid/out_last/fill_level,
//   marked by out_strobe for one cycle. The receiver cannot stall them.
//   An empty drain gives one transaction with out_valid low and out_last high.
//   Configuration: cfg_data is written to the capacity register when
//   cfg_valid and cfg_ready are high; cfg_ready is always high. Write only
//   while idle.
// Timing:
//   Enqueue: accept, then store write. Drain of n words: busy after accept
//   until the last read, one store read per cycle through the single-port
//   word store; results appear in the cycle after each read. An empty drain
//   answers the cycle after accept and the block stays ready.
// Reset: asynchronous, active low; the FIFO empties and capacity returns to
//   16. Store contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module drop_oldest_fifo_burst_drain #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          op,
    input  wire logic [dofbd_pkg::ITEM_W-1:0]  item_data,
    input  wire logic [dofbd_pkg::FILL_W-1:0]  drain_count,
    output logic                               out_strobe,
    output logic      [dofbd_pkg::ITEM_W-1:0]  out_data,
    output logic                               out_valid,
    output logic                               out_last,
    output logic      [dofbd_pkg::FILL_W-1:0]  fill_level,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dofbd_pkg::FILL_W-1:0]  cfg_data
);
    import dofbd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int KW = (DATA_WIDTH < ITEM_W) ? DATA_WIDTH : ITEM_W;

    mem_ctl_t          mem_ctl;
    res_t              res;
    logic [AW-1:0]     mem_addr;
    logic [AW-1:0]     unit_a;
    logic [FILL_W-1:0] unit_b;
    logic [AW-1:0]     unit_sum;
    logic [KW-1:0]     rdata;

    assign cfg_ready = 1'b1;

    dofbd_ptr_unit #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .a   (unit_a),
        .b   (unit_b),
        .sum (unit_sum)
    );

    dofbd_store #(
        .DEPTH (DEPTH),
        .WIDTH (KW)
    ) u_store (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (item_data[KW-1:0]),
        .rdata (rdata)
    );

    dofbd_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .drain_count (drain_count),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .busy        (busy),
        .mem_ctl     (mem_ctl),
        .mem_addr    (mem_addr),
        .unit_a      (unit_a),
        .unit_b      (unit_b),
        .unit_sum    (unit_sum),
        .res         (res)
    );

    // Drive the result transaction; data reads as zero when nothing drained
    assign out_strobe = res.strobe;
    assign out_valid  = res.valid;
    assign out_last   = res.last;
    assign fill_level = res.fill;
    assign out_data   = res.valid ? ITEM_W'(rdata) : '0;

endmodule
`default_nettype wire

// ===== hdl/dofbd_ptr_unit.sv =====
// ----------------------------------------------------------------------------
// dofbd_ptr_unit
// Shared modulo-DEPTH pointer adder used for head advance and tail address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dofbd_ptr_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic [$clog2(DEPTH)-1:0]    a,
    input  wire logic [dofbd_pkg::FILL_W-1:0] b,
    output logic      [$clog2(DEPTH)-1:0]    sum
);
    import dofbd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = ((AW > FILL_W) ? AW : FILL_W) + 1;

    logic [SW-1:0] sum_raw;
    logic [SW-1:0] sum_wrap;

    // Add, then wrap once: both operands stay below DEPTH
    always_comb
    begin
        sum_raw = SW'(a) + SW'(b);
        if (sum_raw >= SW'(DEPTH))
        begin
            sum_wrap = sum_raw - SW'(DEPTH);
        end
        else
        begin
            sum_wrap = sum_raw;
        end
    end

    assign sum = sum_wrap[AW-1:0];

endmodule
`default_nettype wire

// ===== hdl/dofbd_store.sv =====
// ----------------------------------------------------------------------------
// dofbd_store
// Single-port word store with registered read and an input hold register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dofbd_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire dofbd_pkg::mem_ctl_t      ctl,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    import dofbd_pkg::*;

    logic [WIDTH-1:0] word_store_reg [DEPTH];
    logic [WIDTH-1:0] hold_reg;
    logic [WIDTH-1:0] rdata_reg;

    // Hold the incoming word until the write cycle
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            hold_reg <= wdata;
        end
    end

    // Write at the tail, read at the head
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            word_store_reg[addr] <= hold_reg;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= word_store_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hdl/dofbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dofbd_ctrl
// Sequencer: head/fill tracking, drop-oldest decision and burst drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dofbd_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          op,
    input  wire logic [dofbd_pkg::FILL_W-1:0]  drain_count,
    input  wire logic                          cfg_we,
    input  wire logic [dofbd_pkg::FILL_W-1:0]  cfg_data,
    output logic                               busy,
    output dofbd_pkg::mem_ctl_t                mem_ctl,
    output logic      [$clog2(DEPTH)-1:0]      mem_addr,
    output logic      [$clog2(DEPTH)-1:0]      unit_a,
    output logic      [dofbd_pkg::FILL_W-1:0]  unit_b,
    input  wire logic [$clog2(DEPTH)-1:0]      unit_sum,
    output dofbd_pkg::res_t                    res
);
    import dofbd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = ((AW > FILL_W) ? AW : FILL_W) + 1;

    state_t            state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] remain_reg, remain_next;
    logic [FILL_W-1:0] cap_reg;
    res_t              res_reg, res_next;

    logic [FILL_W-1:0] cap_floor;
    logic [SW-1:0]     cap_eff;
    logic              drop;
    logic [FILL_W-1:0] want;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_data;
        end
    end

    // Clamp capacity into 1..DEPTH, decide whether to drop the oldest and limit the drain to the fill
    always_comb
    begin
        cap_floor = (cap_reg == '0) ? FILL_W'(1) : cap_reg;
        cap_eff   = (SW'(cap_floor) > SW'(DEPTH)) ? SW'(DEPTH) : SW'(cap_floor);
        drop      = (SW'(fill_reg) >= cap_eff);
        want      = (drain_count < fill_reg) ? drain_count : fill_reg;
    end

    // State and pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            fill_reg   <= '0;
            remain_reg <= '0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            remain_reg <= remain_next;
            res_reg    <= res_next;
        end
    end

    // Next state, pointer unit operands and store control
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        remain_next = remain_reg;
        res_next    = '0;
        mem_ctl     = '0;
        mem_addr    = head_reg;
        unit_a      = head_reg;
        unit_b      = FILL_W'(1);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mem_ctl.load = 1'b1;
                    if (op == OP_ENQ)
                    begin
                        // Drop the oldest word when full
                        if (drop)
                        begin
                            head_next = unit_sum;
                            fill_next = fill_reg - FILL_W'(1);
                        end
                        state_next = ST_ENQ;
                    end
                    else if (want == '0)
                    begin
                        // Nothing to drain: one invalid, last transaction
                        res_next.strobe = 1'b1;
                        res_next.last   = 1'b1;
                        res_next.fill   = fill_reg;
                    end
                    else
                    begin
                        remain_next = want;
                        state_next  = ST_DRAIN;
                    end
                end
            end
            ST_ENQ:
            begin
                // Write at tail = head + fill
                unit_b        = fill_reg;
                mem_addr      = unit_sum;
                mem_ctl.wr_en = 1'b1;
                fill_next     = fill_reg + FILL_W'(1);
                state_next    = ST_IDLE;
            end
            ST_DRAIN:
            begin
                // Read the head word and advance
                mem_ctl.rd_en   = 1'b1;
                head_next       = unit_sum;
                fill_next       = fill_reg - FILL_W'(1);
                remain_next     = remain_reg - FILL_W'(1);
                res_next.strobe = 1'b1;
                res_next.valid  = 1'b1;
                res_next.last   = (remain_reg == FILL_W'(1));
                res_next.fill   = fill_reg - FILL_W'(1);
                if (remain_reg == FILL_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign res  = res_reg;

    `CHK_ALWAYS(a_fill_bound, clk, rst_n, SW'(fill_reg) <= SW'(DEPTH), "fill exceeds depth")
    `CHK_SAME(a_drain_remain, clk, rst_n, state_reg == ST_DRAIN,
        (remain_reg != '0) && (remain_reg <= fill_reg), "drain count out of range")
    `CHK_NEXT(a_burst_cont, clk, rst_n, res_reg.strobe && !res_reg.last,
        res_reg.strobe && res_reg.valid, "burst broken before last")
    `CHK_NEXT(a_enq_grow, clk, rst_n, state_reg == ST_ENQ,
        fill_reg == $past(fill_reg) + FILL_W'(1), "enqueue did not add a word")

endmodule
`default_nettype wire
